[rtl/core/uack_pkg.sv]
package uack_pkg;

   localparam int unsigned PktLen = 10;
   localparam int unsigned PosWidth = 4;

   localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
   localparam logic [7:0] SYNC_CHAR_2 = 8'h62;
   localparam logic [7:0] ACK_CLASS = 8'h05;
   localparam logic [7:0] NAK_ID = 8'h00;

   // fixed header positions and the payload positions that carry meaning
   localparam logic [PosWidth-1:0] POS_FIRST_PAYLOAD = 4'd3;
   localparam logic [PosWidth-1:0] POS_LAST_SUMMED = 4'd7;
   localparam logic [PosWidth-1:0] POS_ECHO_CLASS = 4'd6;
   localparam logic [PosWidth-1:0] POS_ECHO_ID = 4'd7;
   localparam logic [PosWidth-1:0] POS_CK_A = 4'd8;
   localparam logic [PosWidth-1:0] POS_LAST = 4'd9;

   localparam logic [7:0] EXPECT_CLASS_RESET = 8'd6;
   localparam logic [7:0] EXPECT_MSG_ID_RESET = 8'd49;
   localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd1500;
   localparam logic [15:0] TICK_MAX = 16'hFFFF;

   localparam logic [1:0] KIND_ARM = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [1:0] OUTCOME_ACK = 2'd0;
   localparam logic [1:0] OUTCOME_NAK = 2'd1;
   localparam logic [1:0] OUTCOME_MISMATCH = 2'd2;
   localparam logic [1:0] OUTCOME_TIMEOUT = 2'd3;

   localparam logic [1:0] CSR_EXPECT_CLASS = 2'd0;
   localparam logic [1:0] CSR_EXPECT_MSG_ID = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_LIMIT = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [7:0]  expect_class;
      logic [7:0]  expect_msg_id;
      logic [15:0] timeout_limit;
   } cfg_type;

   typedef struct packed {
      logic       fire;
      logic [1:0] outcome;
   } result_type;

   function automatic logic [7:0] header_byte(input logic [1:0] idx);
      logic [7:0] hb;
      case (idx)
         2'd0: hb = SYNC_CHAR_1;
         2'd1: hb = SYNC_CHAR_2;
         default: hb = ACK_CLASS;
      endcase
      return hb;
   endfunction

endpackage

[rtl/core/uack_engine.sv]
module uack_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  uack_pkg::item_type    item,
   input  uack_pkg::cfg_type     cfg,
   output uack_pkg::result_type  result
);
   import uack_pkg::*;

   logic                armed_ff, armed_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [15:0]         tick_ff, tick_in;
   logic [7:0]          ck_a_ff, ck_a_in;
   logic [7:0]          ck_b_ff, ck_b_in;
   logic [7:0]          echo_class_ff, echo_class_in;
   logic [7:0]          echo_id_ff, echo_id_in;
   logic                ck_a_ok_ff, ck_a_ok_in;
   logic [7:0]          sum_a;
   logic [15:0]         tick_inc;

   // running Fletcher sums start as if byte 2 (0x05) was already summed
   assign sum_a = 8'(ck_a_ff + item.rx_byte);
   assign tick_inc = (tick_ff == TICK_MAX) ? tick_ff : 16'(tick_ff + 16'd1);

   always_comb begin
      armed_in = armed_ff;
      pos_in = pos_ff;
      tick_in = tick_ff;
      ck_a_in = ck_a_ff;
      ck_b_in = ck_b_ff;
      echo_class_in = echo_class_ff;
      echo_id_in = echo_id_ff;
      ck_a_ok_in = ck_a_ok_ff;
      result = '0;
      if (go) begin
         unique case (item.kind)
            KIND_ARM: begin
               armed_in = 1'b1;
               pos_in = '0;
               tick_in = '0;
               ck_a_in = ACK_CLASS;
               ck_b_in = ACK_CLASS;
            end
            KIND_TICK: begin
               if (armed_ff) begin
                  tick_in = tick_inc;
                  if (tick_inc > cfg.timeout_limit) begin
                     armed_in = 1'b0;
                     result.fire = 1'b1;
                     result.outcome = OUTCOME_TIMEOUT;
                  end
               end
            end
            KIND_BYTE: begin
               if (armed_ff) begin
                  if (pos_ff < POS_FIRST_PAYLOAD) begin
                     // header mismatch is dropped, position holds
                     if (item.rx_byte == header_byte(pos_ff[1:0])) begin
                        pos_in = pos_ff + 4'd1;
                     end
                  end else begin
                     pos_in = pos_ff + 4'd1;
                     if (pos_ff <= POS_LAST_SUMMED) begin
                        ck_a_in = sum_a;
                        ck_b_in = 8'(ck_b_ff + sum_a);
                     end
                     if (pos_ff == POS_ECHO_CLASS) begin
                        echo_class_in = item.rx_byte;
                     end
                     if (pos_ff == POS_ECHO_ID) begin
                        echo_id_in = item.rx_byte;
                     end
                     if (pos_ff == POS_CK_A) begin
                        ck_a_ok_in = (item.rx_byte == ck_a_ff);
                     end
                  end
                  if (pos_ff == POS_LAST) begin
                     armed_in = 1'b0;
                     result.fire = 1'b1;
                     if (echo_class_ff == cfg.expect_class && echo_id_ff == cfg.expect_msg_id
                         && ck_a_ok_ff && item.rx_byte == ck_b_ff) begin
                        result.outcome = OUTCOME_ACK;
                     end else begin
                        result.outcome = OUTCOME_MISMATCH;
                     end
                  end else if (tick_ff > cfg.timeout_limit) begin
                     armed_in = 1'b0;
                     result.fire = 1'b1;
                     result.outcome = OUTCOME_TIMEOUT;
                  end else if (pos_ff == POS_FIRST_PAYLOAD && item.rx_byte == NAK_ID) begin
                     armed_in = 1'b0;
                     result.fire = 1'b1;
                     result.outcome = OUTCOME_NAK;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         pos_ff <= '0;
         tick_ff <= '0;
         ck_a_ff <= ACK_CLASS;
         ck_b_ff <= ACK_CLASS;
      end else begin
         armed_ff <= armed_in;
         pos_ff <= pos_in;
         tick_ff <= tick_in;
         ck_a_ff <= ck_a_in;
         ck_b_ff <= ck_b_in;
      end
   end

   always_ff @(posedge clock) begin
      echo_class_ff <= echo_class_in;
      echo_id_ff <= echo_id_in;
      ck_a_ok_ff <= ck_a_ok_in;
   end

`ifndef SYNTHESIS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (pos_ff < 4'(PktLen)))
      else $error("position past packet end while armed");

   a_fire_needs_armed: assert property (@(posedge clock) disable iff (reset)
      result.fire |-> (go && armed_ff))
      else $error("result without an armed wait");

   a_fire_disarms: assert property (@(posedge clock) disable iff (reset)
      result.fire |=> !armed_ff)
      else $error("block still armed after a result");

   a_tick_saturates: assert property (@(posedge clock) disable iff (reset)
      (go && item.kind == KIND_TICK && tick_ff == TICK_MAX) |=> (tick_ff == TICK_MAX))
      else $error("tick counter wrapped");
`endif

endmodule

[rtl/core/ubx_ack_receiver.sv]
// Waits for the acknowledge reply to a command. Each item (arm, received
// byte or millisecond tick) is taken into an input register, handled
// combinationally by the engine, and any outcome lands in a result
// register, so an item can be accepted every cycle while req_stall is low.
// req_stall rises only while the result register is full and stalled.
// Outcomes: 0 ack, 1 nak, 2 id or checksum mismatch, 3 timeout.
// Registers: 0 expected class, 1 expected message id, 2 timeout limit in
// ticks.
module ubx_ack_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_outcome,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import uack_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_outcome_ff;
   logic       out_free;
   logic       advance;
   logic       req_accept;
   result_type result;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expect_class <= EXPECT_CLASS_RESET;
         cfg_ff.expect_msg_id <= EXPECT_MSG_ID_RESET;
         cfg_ff.timeout_limit <= TIMEOUT_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_EXPECT_CLASS: cfg_ff.expect_class <= csr_data[7:0];
            CSR_EXPECT_MSG_ID: cfg_ff.expect_msg_id <= csr_data[7:0];
            CSR_TIMEOUT_LIMIT: cfg_ff.timeout_limit <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.kind <= req_kind;
         in_item_ff.rx_byte <= req_rx_byte;
      end
   end

   uack_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result.fire;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.fire) begin
         rsp_outcome_ff <= result.outcome;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;

endmodule

[verif/ubx_ack_receiver_tb.sv]
module ubx_ack_receiver_tb;
   import uack_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned ITEM_TARGET = 450;
   localparam int unsigned MIN_SEQUENCES = 45;
   localparam int unsigned HOLD_AT = 150;
   localparam int unsigned HOLD_CYCLES = 120;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef enum int unsigned {
      FLAW_NONE,
      FLAW_NAK,
      FLAW_CLASS,
      FLAW_ID,
      FLAW_CKSUM,
      FLAW_PAYLOAD,
      FLAW_TRUNCATED
   } flaw_type;

   typedef struct packed {
      logic        is_csr;
      logic [1:0]  kind;
      logic [7:0]  rx_byte;
      logic [1:0]  csr_index;
      logic [15:0] csr_data;
   } pending_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_ARM;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_outcome;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_EXPECT_CLASS;
   logic [15:0] csr_data = 16'h0000;

   ubx_ack_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_outcome (rsp_outcome),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   pending_op_type pending_ops[$];
   logic [1:0]  outcomes_due[$];
   int unsigned fail_count = 0;
   int unsigned items_accepted = 0;
   int unsigned cycle_count = 0;
   int unsigned item_total = 0;

   // receiver state as the block should hold it
   logic        wait_armed = 1'b0;
   logic [3:0]  wait_pos = '0;
   logic [7:0]  wait_pkt [PktLen];
   logic [15:0] wait_ticks = '0;
   logic [7:0]  cfg_class = EXPECT_CLASS_RESET;
   logic [7:0]  cfg_id = EXPECT_MSG_ID_RESET;
   logic [15:0] cfg_limit = TIMEOUT_LIMIT_RESET;

   // settings the generator builds packets against
   logic [7:0]  plan_class = EXPECT_CLASS_RESET;
   logic [7:0]  plan_id = EXPECT_MSG_ID_RESET;
   logic [15:0] plan_limit = TIMEOUT_LIMIT_RESET;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic clear_wait();
      int unsigned k;
      wait_pos = '0;
      wait_ticks = '0;
      for (k = 0; k < PktLen; k++) wait_pkt[k] = 8'h00;
      wait_pkt[0] = SYNC_CHAR_1;
      wait_pkt[1] = SYNC_CHAR_2;
      wait_pkt[2] = ACK_CLASS;
   endtask

   task automatic predict_outcome(input logic [1:0] kind, input logic [7:0] b);
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      logic       fire;
      logic [1:0] oc;
      int unsigned k;
      fire = 1'b0;
      oc = OUTCOME_ACK;
      if (kind == KIND_ARM) begin
         wait_armed = 1'b1;
         clear_wait();
      end else if (wait_armed && kind == KIND_TICK) begin
         if (wait_ticks != TICK_MAX) wait_ticks = wait_ticks + 16'd1;
         if (wait_ticks > cfg_limit) begin
            fire = 1'b1;
            oc = OUTCOME_TIMEOUT;
         end
      end else if (wait_armed && kind == KIND_BYTE) begin
         if (wait_pos < PktLen) begin
            if (b == wait_pkt[wait_pos]) begin
               wait_pos = wait_pos + 4'd1;
            end else if (wait_pos >= POS_FIRST_PAYLOAD) begin
               wait_pkt[wait_pos] = b;
               wait_pos = wait_pos + 4'd1;
            end
         end
         if (wait_pos >= PktLen) begin
            ck_a = 8'h00;
            ck_b = 8'h00;
            for (k = 2; k <= POS_LAST_SUMMED; k++) begin
               ck_a = ck_a + wait_pkt[k];
               ck_b = ck_b + ck_a;
            end
            fire = 1'b1;
            if (wait_pkt[POS_ECHO_CLASS] == cfg_class && wait_pkt[POS_ECHO_ID] == cfg_id &&
                wait_pkt[POS_CK_A] == ck_a && wait_pkt[POS_LAST] == ck_b)
               oc = OUTCOME_ACK;
            else
               oc = OUTCOME_MISMATCH;
         end else if (wait_ticks > cfg_limit) begin
            // only reachable when the limit was lowered mid-wait
            fire = 1'b1;
            oc = OUTCOME_TIMEOUT;
         end else if (wait_pos == POS_FIRST_PAYLOAD + 4'd1 &&
                      wait_pkt[POS_FIRST_PAYLOAD] == NAK_ID) begin
            fire = 1'b1;
            oc = OUTCOME_NAK;
         end
      end
      if (fire) begin
         wait_armed = 1'b0;
         outcomes_due.push_back(oc);
      end
   endtask

   task automatic queue_item(input logic [1:0] kind, input logic [7:0] b);
      pending_op_type op;
      op = '0;
      op.kind = kind;
      op.rx_byte = b;
      pending_ops.push_back(op);
      item_total++;
   endtask

   task automatic queue_csr(input logic [1:0] idx, input logic [15:0] data);
      pending_op_type op;
      op = '0;
      op.is_csr = 1'b1;
      op.csr_index = idx;
      op.csr_data = data;
      pending_ops.push_back(op);
      case (idx)
         CSR_EXPECT_CLASS: plan_class = data[7:0];
         CSR_EXPECT_MSG_ID: plan_id = data[7:0];
         default: plan_limit = data;
      endcase
   endtask

   // arm, then an ACK frame for the planned class/id, with optional damage,
   // stray ticks and header noise mixed in
   task automatic queue_packet(input flaw_type flaw, input int unsigned tick_pct,
                               input int unsigned noise_pct);
      logic [7:0]  pkt [PktLen];
      logic [7:0]  ck_a;
      logic [7:0]  ck_b;
      int unsigned k;
      int unsigned stop;
      pkt[0] = SYNC_CHAR_1;
      pkt[1] = SYNC_CHAR_2;
      pkt[2] = ACK_CLASS;
      pkt[3] = 8'h01;
      pkt[4] = 8'h02;
      pkt[5] = 8'h00;
      pkt[6] = plan_class;
      pkt[7] = plan_id;
      case (flaw)
         FLAW_NAK: pkt[3] = NAK_ID;
         FLAW_CLASS: pkt[6] = plan_class ^ (8'd1 << $urandom_range(0, 7));
         FLAW_ID: pkt[7] = plan_id ^ (8'd1 << $urandom_range(0, 7));
         FLAW_PAYLOAD: pkt[$urandom_range(3, 5)] = 8'($urandom);
         default: ;
      endcase
      ck_a = 8'h00;
      ck_b = 8'h00;
      for (k = 2; k < 8; k++) begin
         ck_a = ck_a + pkt[k];
         ck_b = ck_b + ck_a;
      end
      pkt[8] = ck_a;
      pkt[9] = ck_b;
      if (flaw == FLAW_CKSUM) pkt[$urandom_range(8, 9)] ^= 8'($urandom_range(1, 255));
      if (flaw == FLAW_NAK) stop = 4;
      else if (flaw == FLAW_TRUNCATED) stop = $urandom_range(1, PktLen - 1);
      else stop = PktLen;
      queue_item(KIND_ARM, 8'($urandom));
      for (k = 0; k < stop; k++) begin
         if ($urandom_range(0, 99) < tick_pct) queue_item(KIND_TICK, 8'($urandom));
         if (k < 3 && $urandom_range(0, 99) < noise_pct) queue_item(KIND_BYTE, 8'($urandom));
         queue_item(KIND_BYTE, pkt[k]);
      end
   endtask

   // sender: bursts and gaps, config writes only once the block has drained
   int unsigned gap_left = 0;
   int unsigned burst_left = 1;
   int unsigned quiet = 0;

   always @(posedge clock) begin
      logic           hold_item;
      logic           next_valid;
      logic           next_write;
      pending_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
         req_kind <= KIND_ARM;
         req_rx_byte <= 8'h00;
         csr_write <= 1'b0;
         csr_index <= CSR_EXPECT_CLASS;
         csr_data <= 16'h0000;
         gap_left = 0;
         burst_left = 1;
         quiet = 0;
      end else begin
         hold_item = req_valid && req_stall;
         next_valid = hold_item;
         next_write = 1'b0;
         if (req_valid && !req_stall) begin
            predict_outcome(req_kind, req_rx_byte);
            items_accepted++;
            quiet = 0;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else if (quiet < SETTLE_CYCLES) begin
            quiet++;
         end
         if (!hold_item) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_ops.size() > 0) begin
               op = pending_ops[0];
               if (!op.is_csr) begin
                  op = pending_ops.pop_front();
                  next_valid = 1'b1;
                  req_kind <= op.kind;
                  req_rx_byte <= op.rx_byte;
               end else if (outcomes_due.size() == 0 && quiet >= SETTLE_CYCLES) begin
                  op = pending_ops.pop_front();
                  next_write = 1'b1;
                  csr_index <= op.csr_index;
                  csr_data <= op.csr_data;
                  case (op.csr_index)
                     CSR_EXPECT_CLASS: cfg_class = op.csr_data[7:0];
                     CSR_EXPECT_MSG_ID: cfg_id = op.csr_data[7:0];
                     CSR_TIMEOUT_LIMIT: cfg_limit = op.csr_data;
                     default: ;
                  endcase
               end
            end
         end
         req_valid <= next_valid;
         csr_write <= next_write;
      end
   end

   // receiver: checks outcomes, stalls with a changing duty, one long hold
   int unsigned stall_pct = 0;
   int unsigned mode_left = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;

   always @(posedge clock) begin
      logic       next_stall;
      logic [1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcomes_due.size() == 0) begin
               $error("outcome: expected none, actual %0d", rsp_outcome);
               fail_count++;
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_outcome !== want) begin
                  $error("outcome: expected %0d, actual %0d", want, rsp_outcome);
                  fail_count++;
               end
            end
         end
         if (mode_left == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 50;
               default: stall_pct = 80;
            endcase
            mode_left = $urandom_range(10, 60);
         end else begin
            mode_left--;
         end
         next_stall = ($urandom_range(0, 99) < stall_pct);
         if (!hold_done && items_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            next_stall = 1'b1;
            hold_left--;
         end
         rsp_stall <= next_stall;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ubx_ack_receiver test failed");
         $finish;
      end
   end

   initial begin
      int unsigned seq_count;
      int unsigned pick;
      int unsigned tick_pct;
      int unsigned k;
      logic [7:0]  val;

      clear_wait();

      // directed
      queue_csr(CSR_EXPECT_CLASS, {8'h00, EXPECT_CLASS_RESET});
      queue_csr(CSR_EXPECT_MSG_ID, {8'h00, EXPECT_MSG_ID_RESET});
      queue_csr(CSR_TIMEOUT_LIMIT, TIMEOUT_LIMIT_RESET);
      queue_item(KIND_BYTE, 8'hFF);      // idle: ignored
      queue_item(KIND_TICK, 8'h00);
      queue_item(KIND_UNUSED, 8'hAA);
      queue_packet(FLAW_NAK, 0, 0);
      queue_packet(FLAW_NONE, 0, 0);
      // limit lowered while waiting: next byte reports timeout
      queue_item(KIND_ARM, 8'h55);
      queue_item(KIND_TICK, 8'h00);
      queue_item(KIND_TICK, 8'h00);
      queue_csr(CSR_TIMEOUT_LIMIT, 16'd1);
      queue_item(KIND_BYTE, SYNC_CHAR_1);
      // zero limit: first tick times out
      queue_csr(CSR_TIMEOUT_LIMIT, 16'd0);
      queue_item(KIND_ARM, 8'h00);
      queue_item(KIND_TICK, 8'hFF);

      // random phases
      seq_count = 0;
      while (item_total < ITEM_TARGET || seq_count < MIN_SEQUENCES) begin
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
               0: val = 8'h00;
               1: val = 8'hFF;
               default: val = 8'($urandom);
            endcase
            queue_csr(CSR_EXPECT_CLASS, {8'($urandom), val});
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
               0: val = 8'h00;
               1: val = 8'hFF;
               default: val = 8'($urandom);
            endcase
            queue_csr(CSR_EXPECT_MSG_ID, {8'($urandom), val});
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0: queue_csr(CSR_TIMEOUT_LIMIT, 16'd0);
               1: queue_csr(CSR_TIMEOUT_LIMIT, 16'd1);
               2: queue_csr(CSR_TIMEOUT_LIMIT, 16'hFFFF);
               3, 4, 5: queue_csr(CSR_TIMEOUT_LIMIT, 16'($urandom_range(2, 20)));
               default: queue_csr(CSR_TIMEOUT_LIMIT, 16'($urandom_range(100, 65535)));
            endcase
         end
         repeat ($urandom_range(3, 6)) begin
            seq_count++;
            tick_pct = (plan_limit < 40) ? $urandom_range(0, 15) : $urandom_range(0, 10);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               queue_packet(FLAW_NONE, tick_pct, $urandom_range(0, 20));
            end else if (pick < 70) begin
               queue_packet(flaw_type'($urandom_range(FLAW_CLASS, FLAW_TRUNCATED)), tick_pct,
                            $urandom_range(0, 20));
            end else if (pick < 80) begin
               queue_packet(FLAW_NAK, tick_pct, $urandom_range(0, 20));
            end else if (pick < 90) begin
               // any kind, any byte, unused kind included
               repeat ($urandom_range(4, 12))
                  queue_item(2'($urandom_range(0, 3)), 8'($urandom));
            end else if (plan_limit <= 40) begin
               queue_item(KIND_ARM, 8'($urandom));
               for (k = 0; k <= plan_limit; k++) queue_item(KIND_TICK, 8'($urandom));
            end else begin
               queue_packet(FLAW_NONE, 0, 0);
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (pending_ops.size() != 0 || req_valid || outcomes_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && outcomes_due.size() == 0) begin
         $display("ubx_ack_receiver test passed");
      end else begin
         $display("ubx_ack_receiver test failed");
      end
      $finish;
   end

endmodule

[ubx_ack_receiver.f]
rtl/core/uack_pkg.sv
rtl/core/uack_engine.sv
rtl/core/ubx_ack_receiver.sv
verif/ubx_ack_receiver_tb.sv
